// File: design/adeq_pkg.sv
// Shared types and constants for the array double-ended queue.
package adeq_pkg;

    // Number of slots in the array, the value width and the other widths.
    localparam int DEPTH = 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VAL_W = 32;
    localparam int OCC_W = 4;
    localparam int SUM_W = (IDX_W + 1 > OCC_W) ? IDX_W + 1 : OCC_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // Operation codes carried by an input item.
    typedef enum logic [1:0] {
        CMD_PUSH_BACK  = 2'd0,
        CMD_POP_FRONT  = 2'd1,
        CMD_PUSH_FRONT = 2'd2,
        CMD_POP_BACK   = 2'd3
    } t_cmd;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_NO_ROOM = 2'd1,
        STAT_EMPTY   = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    // Access request from the controller to the slot memory.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [VAL_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

endpackage

// File: design/adeq_if.sv
// Valid/ready channels for request items and result items.
interface adeq_req_if;
    import adeq_pkg::*;

    logic                    valid;
    logic                    ready;
    t_cmd                    cmd;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink (input valid, input cmd, input value, output ready);
endinterface

interface adeq_rsp_if;
    import adeq_pkg::*;

    logic                    valid;
    logic                    ready;
    t_status                 status;
    logic signed [VAL_W-1:0] removed_value;
    logic [OCC_W-1:0]        occupancy;

    modport source (output valid, output status, output removed_value, output occupancy,
                    input ready);
    modport sink (input valid, input status, input removed_value, input occupancy,
                  output ready);
endinterface

// File: design/adeq_ram.sv
// Generic single-write, single-read memory with a registered read port.
module adeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/adeq_ctrl.sv
// Index bookkeeping, command decode and result register of the queue.
module adeq_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    adeq_req_if.sink                  i_req,
    adeq_rsp_if.source                o_rsp,
    output adeq_pkg::t_mem_req        o_mem,
    input  logic [adeq_pkg::VAL_W-1:0] i_rdata
);
    import adeq_pkg::*;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_front, n_front;
    logic [IDX_W-1:0] r_back, n_back;
    logic             r_empty, n_empty;
    logic             r_out_valid, n_out_valid;
    t_status          r_status, n_status;
    logic [VAL_W-1:0] r_removed;
    logic [OCC_W-1:0] r_occ, n_occ;
    logic [SUM_W-1:0] held;
    logic             accept;
    t_mem_req         mem_req;

    assign accept = i_req.valid && i_req.ready;

    // Decode the command against the current indices.
    always_comb begin
        n_front       = r_front;
        n_back        = r_back;
        n_empty       = r_empty;
        n_status      = STAT_DONE;
        mem_req.we    = 1'b0;
        mem_req.waddr = r_back;
        mem_req.wdata = i_req.value;
        mem_req.re    = 1'b0;
        mem_req.raddr = r_front;
        unique case (i_req.cmd) inside
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                if (r_empty) begin
                    n_front       = '0;
                    n_back        = '0;
                    n_empty       = 1'b0;
                    mem_req.we    = 1'b1;
                    mem_req.waddr = '0;
                end else if (i_req.cmd == CMD_PUSH_BACK) begin
                    if (r_back == LAST_IDX) begin
                        n_status = STAT_NO_ROOM;
                    end else begin
                        n_back        = r_back + 1'b1;
                        mem_req.we    = 1'b1;
                        mem_req.waddr = r_back + 1'b1;
                    end
                end else begin
                    if (r_front == '0) begin
                        n_status = STAT_NO_ROOM;
                    end else begin
                        n_front       = r_front - 1'b1;
                        mem_req.we    = 1'b1;
                        mem_req.waddr = r_front - 1'b1;
                    end
                end
            end
            default: begin
                if (r_empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = (i_req.cmd == CMD_POP_FRONT) ? r_front : r_back;
                    if (r_front == r_back) begin
                        n_empty = 1'b1;
                        n_front = '0;
                        n_back  = '0;
                    end else if (i_req.cmd == CMD_POP_FRONT) begin
                        n_front = r_front + 1'b1;
                    end else begin
                        n_back = r_back - 1'b1;
                    end
                end
            end
        endcase
        // Only an accepted item touches the memory.
        mem_req.we = mem_req.we && accept;
        mem_req.re = mem_req.re && accept;
    end

    // Occupancy after the operation, masked to the field width.
    always_comb begin
        held  = SUM_W'(n_back) - SUM_W'(n_front) + SUM_W'(1);
        n_occ = n_empty ? '0 : held[OCC_W-1:0];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (mem_req.re) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs and result valid.
    always_comb begin
        i_req.ready = 1'b0;
        n_out_valid = r_out_valid && !o_rsp.ready;
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready = !r_out_valid || o_rsp.ready;
                if (accept) begin
                    n_out_valid = !mem_req.re;
                end
            end
            ST_READ: n_out_valid = 1'b1;
            default: n_out_valid = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_front     <= '0;
            r_back      <= '0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_front <= n_front;
                r_back  <= n_back;
                r_empty <= n_empty;
            end
        end
    end

    // Result payload; a removal fills in its value when the read returns.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_occ     <= n_occ;
            r_removed <= '0;
        end else if (r_state == ST_READ) begin
            r_removed <= i_rdata;
        end
    end

    assign o_mem                 = mem_req;
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_status;
    assign o_rsp.removed_value   = r_removed;
    assign o_rsp.occupancy       = r_occ;

endmodule

// File: design/array_double_ended_queue.sv
// Top level of the double-ended queue kept in a fixed, non-wrapping array.
//
// Usage: request items arrive on i_req (valid/ready) with a command and a
// value; each item yields exactly one result item on o_rsp (valid/ready)
// with a status, the removed value and the occupancy after the operation.
// Inserts with room write the slot memory in the cycle of acceptance, and
// their result is valid in the next cycle. A successful removal reads
// the registered read port of the slot memory; the controller waits in
// ST_READ and then registers the result. Throughput is one item per cycle
// for inserts and failed operations while results are taken; no new item
// is taken in ST_READ, so a removal must finish before the next item.
// A new item is taken while the previous result waits only if that result
// is taken in the same cycle; a stalled receiver holds the result register
// and i_req.ready stays low until it drains.
// Reset (synchronous, active low) empties the queue and clears both
// indices; slot contents are not cleared and need no clearing pass.
module array_double_ended_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    adeq_req_if.sink    i_req,
    adeq_rsp_if.source  o_rsp
);
    import adeq_pkg::*;

    t_mem_req         mem_req;
    logic [VAL_W-1:0] rdata;

    // Command decode, indices and result register.
    adeq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_mem   (mem_req),
        .i_rdata (rdata)
    );

    // Slot storage.
    adeq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (rdata)
    );

endmodule
